>>> src/ecc_ead_pkg.sv
`default_nettype none

package ecc_ead_pkg;

    localparam int ADDR_W = 39;

    // Result of one interleave level: which side, and the address within it
    typedef struct packed {
        logic              side;
        logic [ADDR_W-1:0] rest;
    } split_t;

endpackage

`default_nettype wire

>>> src/ecc_ead_split.sv
`default_nettype none

module ecc_ead_split (
    input  wire logic [ecc_ead_pkg::ADDR_W-1:0] addr,
    input  wire logic [31:0]                    hash,
    input  wire logic [ecc_ead_pkg::ADDR_W-1:0] small_size,
    input  wire logic                           large_side,
    output ecc_ead_pkg::split_t                 split
);
    import ecc_ead_pkg::*;

    logic              above_small;
    logic              hash_mode;
    logic              parity;
    logic [2:0]        ilv_sel;
    logic [7:0]        ilv_bits;
    logic              ilv_bit;
    logic [3:0]        pos;
    logic [ADDR_W-1:0] low_mask;
    logic [ADDR_W-1:0] dropped;

    always_comb
    begin
        above_small = {1'b0, addr} > {small_size, 1'b0};
        hash_mode   = hash[28];
        parity      = ^(addr[19:6] & hash[19:6]);
        // interleave bit sits at 6 + lsb field in hash mode, else at bit 6
        ilv_sel     = hash_mode ? hash[26:24] : 3'd0;
        ilv_bits    = addr[13:6];
        ilv_bit     = ilv_bits[ilv_sel];
        pos         = {1'b0, ilv_sel} + 4'd6;
        low_mask    = (ADDR_W'(1) << pos) - ADDR_W'(1);
        // drop the interleave bit and close the gap
        dropped     = ((addr >> (pos + 4'd1)) << pos) | (addr & low_mask);

        if (above_small)
        begin
            split.side = large_side;
            split.rest = addr - small_size;
        end
        else
        begin
            split.side = hash_mode ? (parity ^ ilv_bit) : ilv_bit;
            split.rest = dropped;
        end
    end

endmodule

`default_nettype wire

>>> src/ecc_error_address_decode_core.sv
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   error_log
// out       output     out_valid/out_stall error_present .. dimm_address
// cfg       input      cfg_wr_en           cfg_index, cfg_data
//
// Four register stages: hole addition, hole subtraction, range check with
// channel split, DIMM split. One request per cycle while out is not stalled.
// Reset clears the stage valid bits and all configuration registers.
// A stall on out holds the stage that is full and lets empty stages fill;
// in_stall rises only when every stage holds a request.
`default_nettype none

module ecc_error_address_decode_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [2:0]                     cfg_index,
    input  wire logic [ecc_ead_pkg::ADDR_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [63:0]                    error_log,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                error_present,
    output logic                                uncorrected,
    output logic [15:0]                         syndrome,
    output logic [ecc_ead_pkg::ADDR_W-1:0]      system_address,
    output logic                                out_of_range,
    output logic                                channel,
    output logic [ecc_ead_pkg::ADDR_W-1:0]      channel_address,
    output logic                                dimm_index,
    output logic [ecc_ead_pkg::ADDR_W-1:0]      dimm_address
);
    import ecc_ead_pkg::*;

    typedef enum logic [2:0] {
        REG_LOW_TOP     = 3'd0,
        REG_MEM_TOP     = 3'd1,
        REG_CH_HASH     = 3'd2,
        REG_DIMM_HASH   = 3'd3,
        REG_CH_LAYOUT   = 3'd4,
        REG_DIMM_SMALL  = 3'd5,
        REG_DIMM_LARGE  = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic              error_present;
        logic              uncorrected;
        logic [15:0]       syndrome;
        logic [ADDR_W-1:0] system_address;
    } meta_t;

    localparam logic [ADDR_W:0] FOUR_GIB = (ADDR_W+1)'(64'h1_0000_0000);

    logic [31:0]       low_top_reg;
    logic [ADDR_W-1:0] mem_top_reg;
    logic [31:0]       ch_hash_reg;
    logic [31:0]       dimm_hash_reg;
    logic [8:0]        ch_layout_reg;
    logic [13:0]       dimm_small_reg;
    logic [1:0]        dimm_large_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_top_reg    <= '0;
            mem_top_reg    <= '0;
            ch_hash_reg    <= '0;
            dimm_hash_reg  <= '0;
            ch_layout_reg  <= '0;
            dimm_small_reg <= '0;
            dimm_large_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_index))
                REG_LOW_TOP:    low_top_reg    <= cfg_data[31:0];
                REG_MEM_TOP:    mem_top_reg    <= cfg_data;
                REG_CH_HASH:    ch_hash_reg    <= cfg_data[31:0];
                REG_DIMM_HASH:  dimm_hash_reg  <= cfg_data[31:0];
                REG_CH_LAYOUT:  ch_layout_reg  <= cfg_data[8:0];
                REG_DIMM_SMALL: dimm_small_reg <= cfg_data[13:0];
                REG_DIMM_LARGE: dimm_large_reg <= cfg_data[1:0];
                default:        ;
            endcase
        end
    end

    logic [ADDR_W:0]   tolud;
    logic [ADDR_W:0]   tom;

    assign tolud = {8'd0, low_top_reg[31:20], 20'd0};
    assign tom   = {1'b0, mem_top_reg[ADDR_W-1:20], 20'd0};

    // stage handshake
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready;

    assign s4_ready = !s4_valid_reg || !out_stall;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready) s1_valid_reg <= in_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
            if (s4_ready) s4_valid_reg <= s3_valid_reg;
        end
    end

    // stage 1: extract fields, add the hole, pick the base to subtract
    meta_t           s1_meta_reg, s1_meta_next;
    logic [ADDR_W:0] s1_sum_reg, s1_sum_next;
    logic [ADDR_W:0] s1_base_reg, s1_base_next;
    logic            s1_map_reg, s1_map_next;

    always_comb
    begin
        s1_meta_next.error_present  = error_log[62] | error_log[63];
        s1_meta_next.uncorrected    = error_log[63];
        s1_meta_next.syndrome       = error_log[61:46];
        s1_meta_next.system_address = {error_log[38:5], 5'd0};
        s1_sum_next = {1'b0, s1_meta_next.system_address} + tolud;
        s1_map_next  = 1'b0;
        s1_base_next = FOUR_GIB;
        if ({1'b0, s1_meta_next.system_address} >= tolud)
        begin
            if (tom <= FOUR_GIB)
            begin
                s1_map_next = 1'b1;
            end
            else if ({1'b0, s1_meta_next.system_address} < FOUR_GIB)
            begin
                s1_map_next  = 1'b1;
                s1_base_next = tom;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_meta_reg <= s1_meta_next;
            s1_sum_reg  <= s1_sum_next;
            s1_base_reg <= s1_base_next;
            s1_map_reg  <= s1_map_next;
        end
    end

    // stage 2: subtract the base; a borrow marks a negative mapping
    meta_t           s2_meta_reg;
    logic [ADDR_W:0] s2_addr_reg, s2_addr_next;
    logic            s2_neg_reg, s2_neg_next;
    logic [ADDR_W+1:0] s2_diff;

    always_comb
    begin
        s2_diff = {1'b0, s1_sum_reg} - {1'b0, s1_base_reg};
        if (s1_map_reg)
        begin
            s2_addr_next = s2_diff[ADDR_W:0];
            s2_neg_next  = s2_diff[ADDR_W+1];
        end
        else
        begin
            s2_addr_next = {1'b0, s1_meta_reg.system_address};
            s2_neg_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_meta_reg <= s1_meta_reg;
            s2_addr_reg <= s2_addr_next;
            s2_neg_reg  <= s2_neg_next;
        end
    end

    // stage 3: range check and channel split
    meta_t             s3_meta_reg;
    logic              s3_oor_reg, s3_oor_next;
    split_t            s3_split_reg, s3_split_next;
    split_t            ch_split;

    ecc_ead_split u_ch_split (
        .addr       (s2_addr_reg[ADDR_W-1:0]),
        .hash       (ch_hash_reg),
        .small_size ({2'd0, ch_layout_reg[7:0], 29'd0}),
        .large_side (ch_layout_reg[8]),
        .split      (ch_split)
    );

    always_comb
    begin
        s3_oor_next = s2_neg_reg || (s2_addr_reg >= tom);
        s3_split_next = s3_oor_next ? '0 : ch_split;
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_meta_reg  <= s2_meta_reg;
            s3_oor_reg   <= s3_oor_next;
            s3_split_reg <= s3_split_next;
        end
    end

    // stage 4: DIMM split within the chosen channel
    meta_t  s4_meta_reg;
    logic   s4_oor_reg;
    split_t s4_ch_reg;
    split_t s4_dimm_reg, s4_dimm_next;
    split_t dimm_split;
    logic [6:0] dimm_small;

    assign dimm_small = s3_split_reg.side ? dimm_small_reg[13:7] : dimm_small_reg[6:0];

    ecc_ead_split u_dimm_split (
        .addr       (s3_split_reg.rest),
        .hash       (dimm_hash_reg),
        .small_size ({3'd0, dimm_small, 29'd0}),
        .large_side (dimm_large_reg[s3_split_reg.side]),
        .split      (dimm_split)
    );

    assign s4_dimm_next = s3_oor_reg ? '0 : dimm_split;

    always_ff @(posedge clk)
    begin
        if (s4_ready)
        begin
            s4_meta_reg <= s3_meta_reg;
            s4_oor_reg  <= s3_oor_reg;
            s4_ch_reg   <= s3_split_reg;
            s4_dimm_reg <= s4_dimm_next;
        end
    end

    assign out_valid       = s4_valid_reg;
    assign error_present   = s4_meta_reg.error_present;
    assign uncorrected     = s4_meta_reg.uncorrected;
    assign syndrome        = s4_meta_reg.syndrome;
    assign system_address  = s4_meta_reg.system_address;
    assign out_of_range    = s4_oor_reg;
    assign channel         = s4_ch_reg.side;
    assign channel_address = s4_ch_reg.rest;
    assign dimm_index      = s4_dimm_reg.side;
    assign dimm_address    = s4_dimm_reg.rest;

endmodule

`default_nettype wire
